FILE: rtl/dwp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and codes of the dual wheel position PID block.
package dwp_pkg;

	localparam int INTEGRAL_WIDTH = 48;

	localparam int GAIN_W    = 24;
	localparam int POS_W     = 32;
	localparam int DIST_W    = 24;
	localparam int LIMIT_W   = 16;
	localparam int SCALE_W   = 16;
	localparam int TICK_W    = 8;
	localparam int ELAPSED_W = 17;
	localparam int POWER_W   = 16;
	localparam int CFG_IDX_W = 2;

	// Shared multiplier of each lane: signed 25 x signed 42.
	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 42;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Integral split into an unsigned low part and a signed high part.
	localparam int ILO_W   = 24;
	localparam int IHI_W   = INTEGRAL_WIDTH - ILO_W;
	localparam int ILOP_W  = GAIN_W + ILO_W + 1;
	localparam int PRODI_W = INTEGRAL_WIDTH + GAIN_W;
	localparam int CMP_W   = (PRODI_W > 64) ? PRODI_W : 64;

	localparam int ACC_W    = 58;
	localparam int SUM_W    = 42;
	localparam int SCALED_W = SUM_W + SCALE_W + 1;
	localparam int RND_W    = SCALED_W + 1;
	localparam int Q_W      = RND_W - 16;

	localparam logic signed [CMP_W-1:0] I_LIM = {{(CMP_W-63){1'b0}}, 1'b1, 62'd0};
	localparam logic signed [CMP_W-1:0] BIG   = {{(CMP_W-41){1'b0}}, 1'b1, 40'd0};

	localparam logic [TICK_W-1:0] TICK_RESET = 8'd10;

	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P = 2'd0,
		CFG_GAIN_I = 2'd1,
		CFG_GAIN_D = 2'd2,
		CFG_TICK   = 2'd3
	} dwp_cfg_idx_t;

	typedef enum logic [3:0] {
		STEP_NONE,
		STEP_ERR,
		STEP_MP,
		STEP_MD,
		STEP_MIL,
		STEP_MIH,
		STEP_ACCI,
		STEP_SUM,
		STEP_MS,
		STEP_RND
	} dwp_step_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_MP,
		ST_MD,
		ST_MIL,
		ST_MIH,
		ST_ACCI,
		ST_SUM,
		ST_MS,
		ST_RND,
		ST_FIN,
		ST_OUT
	} dwp_state_t;

	typedef struct packed {
		logic      take_in;
		dwp_step_t step;
		logic      finish;
		logic      load_out;
	} dwp_cmd_t;

	typedef struct packed {
		logic tick_in;
		logic moving;
		logic expired;
	} dwp_status_t;

endpackage

FILE: rtl/dwp_lane.sv
`timescale 1ns / 1ps
// One wheel side of the datapath: PID state, shared multiplier and rounding.
module dwp_lane import dwp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dwp_cmd_t                  cmd,
	input  logic                      start,
	input  logic signed [POS_W-1:0]   position,
	input  logic signed [DIST_W-1:0]  distance,
	input  logic signed [GAIN_W-1:0]  gain_p,
	input  logic signed [GAIN_W-1:0]  gain_i,
	input  logic signed [GAIN_W-1:0]  gain_d,
	input  logic [SCALE_W-1:0]        scale,
	output logic signed [POWER_W-1:0] power
);

	// Saturate a 33-bit signed value to 32 bits.
	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
		if (v[POS_W] != v[POS_W-1])
			sat_pos = {v[POS_W], {(POS_W-1){~v[POS_W]}}};
		else
			sat_pos = v[POS_W-1:0];
	endfunction

	logic signed [POS_W-1:0]          target_q, last_q, pos_q, err_q;
	logic signed [POS_W:0]            dif_q;
	logic signed [INTEGRAL_WIDTH-1:0] integ_q;
	logic signed [MUL_P_W-1:0]        prod_q;
	logic signed [ACC_W-1:0]          acc_q;
	logic signed [PRODI_W-1:0]        ip_q;
	logic signed [SUM_W-1:0]          sum_q;
	logic signed [POWER_W-1:0]        power_q;

	logic signed [POS_W:0]            tgt_raw, err_raw, dif_n;
	logic signed [POS_W-1:0]          err_n;
	logic signed [INTEGRAL_WIDTH:0]   integ_raw;
	logic signed [INTEGRAL_WIDTH-1:0] integ_n;
	logic signed [MUL_A_W-1:0]        mul_a;
	logic signed [MUL_B_W-1:0]        mul_b;
	logic signed [MUL_P_W-1:0]        prod_n;
	logic signed [CMP_W-1:0]          ipx, accx, sum_full, sum_c;
	logic                             in_range;
	logic signed [SCALED_W-1:0]       scaled;
	logic signed [RND_W-1:0]          rnd;
	logic signed [Q_W-1:0]            q;
	logic signed [POWER_W-1:0]        power_n;

	assign tgt_raw = {position[POS_W-1], position}
		+ {{(POS_W+1-DIST_W){distance[DIST_W-1]}}, distance};

	// Error, first difference and saturating integral update.
	assign err_raw   = {target_q[POS_W-1], target_q} - {pos_q[POS_W-1], pos_q};
	assign err_n     = sat_pos(err_raw);
	assign dif_n     = {err_n[POS_W-1], err_n} - {last_q[POS_W-1], last_q};
	assign integ_raw = {integ_q[INTEGRAL_WIDTH-1], integ_q}
		+ {{(INTEGRAL_WIDTH+1-POS_W){err_n[POS_W-1]}}, err_n};
	assign integ_n   = (integ_raw[INTEGRAL_WIDTH] != integ_raw[INTEGRAL_WIDTH-1])
		? {integ_raw[INTEGRAL_WIDTH], {(INTEGRAL_WIDTH-1){~integ_raw[INTEGRAL_WIDTH]}}}
		: integ_raw[INTEGRAL_WIDTH-1:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.step)
			STEP_MP: begin
				mul_a = {{(MUL_A_W-GAIN_W){gain_p[GAIN_W-1]}}, gain_p};
				mul_b = {{(MUL_B_W-POS_W){err_q[POS_W-1]}}, err_q};
			end
			STEP_MD: begin
				mul_a = {{(MUL_A_W-GAIN_W){gain_d[GAIN_W-1]}}, gain_d};
				mul_b = {{(MUL_B_W-POS_W-1){dif_q[POS_W]}}, dif_q};
			end
			STEP_MIL: begin
				mul_a = {{(MUL_A_W-GAIN_W){gain_i[GAIN_W-1]}}, gain_i};
				mul_b = {{(MUL_B_W-ILO_W){1'b0}}, integ_q[ILO_W-1:0]};
			end
			STEP_MIH: begin
				mul_a = {{(MUL_A_W-GAIN_W){gain_i[GAIN_W-1]}}, gain_i};
				mul_b = {{(MUL_B_W-IHI_W){integ_q[INTEGRAL_WIDTH-1]}},
					integ_q[INTEGRAL_WIDTH-1:ILO_W]};
			end
			STEP_MS: begin
				mul_a = {{(MUL_A_W-SCALE_W){1'b0}}, scale};
				mul_b = sum_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_n = mul_a * mul_b;

	// The integral term counts only while its magnitude stays within 2^62;
	// beyond that the whole sum is forced to +/-2^40 with the integral term's sign.
	assign ipx      = {{(CMP_W-PRODI_W){ip_q[PRODI_W-1]}}, ip_q};
	assign accx     = {{(CMP_W-ACC_W){acc_q[ACC_W-1]}}, acc_q};
	assign sum_full = accx + ipx;
	assign in_range = (ipx <= I_LIM) && (ipx >= -I_LIM);

	always_comb begin
		if (!in_range)
			sum_c = ipx[CMP_W-1] ? -BIG : BIG;
		else if (sum_full > BIG)
			sum_c = BIG;
		else if (sum_full < -BIG)
			sum_c = -BIG;
		else
			sum_c = sum_full;
	end

	// Round half up to Q1.15 and saturate.
	assign scaled = prod_q[SCALED_W-1:0];
	assign rnd    = {scaled[SCALED_W-1], scaled} + RND_W'(32768);
	assign q      = rnd[RND_W-1:16];
	assign power_n = (q[Q_W-1:POWER_W-1] != {(Q_W-POWER_W+1){q[POWER_W-1]}})
		? {q[Q_W-1], {(POWER_W-1){~q[Q_W-1]}}}
		: q[POWER_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			integ_q  <= '0;
			last_q   <= '0;
		end else if (start) begin
			target_q <= sat_pos(tgt_raw);
			integ_q  <= '0;
			last_q   <= '0;
		end else if (cmd.step == STEP_ERR) begin
			integ_q <= integ_n;
			last_q  <= err_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in)
			pos_q <= position;
		case (cmd.step)
			STEP_ERR: begin
				err_q <= err_n;
				dif_q <= dif_n;
			end
			STEP_MP: prod_q <= prod_n;
			STEP_MD: begin
				prod_q <= prod_n;
				acc_q  <= prod_q[ACC_W-1:0];
			end
			STEP_MIL: begin
				prod_q <= prod_n;
				acc_q  <= acc_q + prod_q[ACC_W-1:0];
			end
			STEP_MIH: begin
				prod_q <= prod_n;
				ip_q   <= {{(PRODI_W-ILOP_W){prod_q[ILOP_W-1]}}, prod_q[ILOP_W-1:0]};
			end
			STEP_ACCI: ip_q <= ip_q + {prod_q[INTEGRAL_WIDTH-1:0], {ILO_W{1'b0}}};
			STEP_SUM:  sum_q <= sum_c[SUM_W-1:0];
			STEP_MS:   prod_q <= prod_n;
			STEP_RND:  power_q <= power_n;
			default: ;
		endcase
	end

	assign power = power_q;

endmodule

FILE: rtl/dwp_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, move timing, both lanes and the result register.
module dwp_datapath import dwp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dwp_cmd_t                  cmd,
	output dwp_status_t               status,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [GAIN_W-1:0]         cfg_data,
	input  logic                      operation,
	input  logic signed [POS_W-1:0]   left_position,
	input  logic signed [POS_W-1:0]   right_position,
	input  logic signed [DIST_W-1:0]  left_distance,
	input  logic signed [DIST_W-1:0]  right_distance,
	input  logic [LIMIT_W-1:0]        time_limit_ms,
	input  logic [SCALE_W-1:0]        speed_scale,
	output logic signed [POWER_W-1:0] left_power,
	output logic signed [POWER_W-1:0] right_power,
	output logic                      move_done
);

	logic signed [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic [TICK_W-1:0]         tick_q;
	logic                      moving_q, done_pend_q;
	logic [ELAPSED_W-1:0]      elapsed_q;
	logic [LIMIT_W-1:0]        limit_q;
	logic [SCALE_W-1:0]        scale_q;
	logic signed [POWER_W-1:0] left_power_q, right_power_q, lane_left, lane_right;
	logic                      move_done_q;
	logic                      start;

	assign start = cmd.take_in && (operation == OP_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			tick_q   <= TICK_RESET;
		end else if (cfg_we) begin
			case (dwp_cfg_idx_t'(cfg_index))
				CFG_GAIN_P: gain_p_q <= cfg_data;
				CFG_GAIN_I: gain_i_q <= cfg_data;
				CFG_GAIN_D: gain_d_q <= cfg_data;
				CFG_TICK:   tick_q   <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q    <= 1'b0;
			done_pend_q <= 1'b0;
			elapsed_q   <= '0;
			limit_q     <= '0;
			scale_q     <= '0;
		end else begin
			if (start) begin
				moving_q  <= 1'b1;
				elapsed_q <= '0;
				limit_q   <= time_limit_ms;
				scale_q   <= speed_scale;
			end else if (cmd.finish) begin
				moving_q    <= 1'b0;
				done_pend_q <= 1'b1;
			end else if (cmd.step == STEP_ERR) begin
				done_pend_q <= 1'b0;
				elapsed_q   <= elapsed_q + {{(ELAPSED_W-TICK_W){1'b0}}, tick_q};
			end
		end
	end

	assign status.tick_in = (operation == OP_TICK);
	assign status.moving  = moving_q;
	assign status.expired = (elapsed_q >= {{(ELAPSED_W-LIMIT_W){1'b0}}, limit_q});

	dwp_lane u_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.start    (start),
		.position (left_position),
		.distance (left_distance),
		.gain_p   (gain_p_q),
		.gain_i   (gain_i_q),
		.gain_d   (gain_d_q),
		.scale    (scale_q),
		.power    (lane_left)
	);

	dwp_lane u_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.start    (start),
		.position (right_position),
		.distance (right_distance),
		.gain_p   (gain_p_q),
		.gain_i   (gain_i_q),
		.gain_d   (gain_d_q),
		.scale    (scale_q),
		.power    (lane_right)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			left_power_q  <= done_pend_q ? '0 : lane_left;
			right_power_q <= done_pend_q ? '0 : lane_right;
			move_done_q   <= done_pend_q;
		end
	end

	assign left_power  = left_power_q;
	assign right_power = right_power_q;
	assign move_done   = move_done_q;

endmodule

FILE: rtl/dwp_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences each item through the datapath and owns the result handshake.
module dwp_ctrl import dwp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  dwp_status_t status,
	output dwp_cmd_t    cmd
);

	dwp_state_t state_q, state_n;
	logic       out_valid_q;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && status.tick_in && status.moving)
					state_n = status.expired ? ST_FIN : ST_ERR;
			end
			ST_ERR:  state_n = ST_MP;
			ST_MP:   state_n = ST_MD;
			ST_MD:   state_n = ST_MIL;
			ST_MIL:  state_n = ST_MIH;
			ST_MIH:  state_n = ST_ACCI;
			ST_ACCI: state_n = ST_SUM;
			ST_SUM:  state_n = ST_MS;
			ST_MS:   state_n = ST_RND;
			ST_RND:  state_n = ST_OUT;
			ST_FIN:  state_n = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || out_ready)
					state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.take_in  = 1'b0;
		cmd.step     = STEP_NONE;
		cmd.finish   = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.take_in = in_valid;
			end
			ST_ERR:  cmd.step = STEP_ERR;
			ST_MP:   cmd.step = STEP_MP;
			ST_MD:   cmd.step = STEP_MD;
			ST_MIL:  cmd.step = STEP_MIL;
			ST_MIH:  cmd.step = STEP_MIH;
			ST_ACCI: cmd.step = STEP_ACCI;
			ST_SUM:  cmd.step = STEP_SUM;
			ST_MS:   cmd.step = STEP_MS;
			ST_RND:  cmd.step = STEP_RND;
			ST_FIN:  cmd.finish = 1'b1;
			ST_OUT:  cmd.load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/dual_wheel_position_pid_top.sv
`timescale 1ns / 1ps
// Top level of the two-channel position PID controller with a move time limit.
//
// Input channel (in_valid/in_ready): each item is a start (operation 0) or a
// control tick (operation 1) with both encoder positions. A start latches both
// targets, the time limit and the speed scale and gives no result. A tick
// while a move runs gives one result item on the output channel
// (out_valid/out_ready); a tick while idle is taken and dropped.
// A computed tick runs the nine-step sequence through one 25x42 multiplier per
// wheel side and then loads the output register; the tick that ends the move
// goes through the finish step and then loads the output register. No new
// item is taken while a tick runs: in_ready returns high once the result sits
// in the output register. Starts are taken one item per cycle while idle.
// When the receiver stalls, the output register holds its item. The block
// keeps taking items, but the next tick that gives a result waits with
// in_ready low until the held item is taken. Configuration writes
// (cfg_valid/cfg_data, cfg_index picks gain_p, gain_i, gain_d or
// tick_period_ms) are always ready and belong in idle periods. Reset clears
// the gains, sets the tick period to 10 ms and leaves the block idle with no
// move running and no result pending.
module dual_wheel_position_pid_top import dwp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      operation,
	input  logic signed [POS_W-1:0]   left_position,
	input  logic signed [POS_W-1:0]   right_position,
	input  logic signed [DIST_W-1:0]  left_distance,
	input  logic signed [DIST_W-1:0]  right_distance,
	input  logic [LIMIT_W-1:0]        time_limit_ms,
	input  logic [SCALE_W-1:0]        speed_scale,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [POWER_W-1:0] left_power,
	output logic signed [POWER_W-1:0] right_power,
	output logic                      move_done,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [GAIN_W-1:0]         cfg_data
);

	dwp_cmd_t    cmd;
	dwp_status_t status;

	// Register writes are stored directly, so the port never back-pressures.
	assign cfg_ready = 1'b1;

	dwp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	dwp_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.operation      (operation),
		.left_position  (left_position),
		.right_position (right_position),
		.left_distance  (left_distance),
		.right_distance (right_distance),
		.time_limit_ms  (time_limit_ms),
		.speed_scale    (speed_scale),
		.left_power     (left_power),
		.right_power    (right_power),
		.move_done      (move_done)
	);

endmodule
